/* hdl/wly_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wly_pkg
// Shared constants of the cellular-noise pixel warp: hash multipliers and
// the latency of one noise evaluation.
// ----------------------------------------------------------------------------
package wly_pkg;

	localparam logic [31:0] HASH_MUL_X = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
	localparam logic [31:0] HASH_MIX   = 32'd1274126177;

	// Registered stages of one noise evaluation: nine datapath stages plus one
	// per root bit (FRAC_BITS + 2 root bits).
	function automatic int noise_lat(int frac);
		return frac + 11;
	endfunction

endpackage

/* hdl/wly_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wly_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wly_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/wly_noise.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wly_noise
// One 3x3-cell cellular noise evaluation: cell hash, feature offsets, nine
// squared distances, registered minimum tree and a pipelined integer root.
// ----------------------------------------------------------------------------
module wly_noise #(
	parameter int FRAC_BITS = 12,
	parameter int PW        = 27
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [PW-1:0]   px,
	input  logic signed [PW-1:0]   py,
	output logic [FRAC_BITS+1:0]   nval
);
	import wly_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int IW  = PW - F;
	localparam int DXW = F + 3;
	localparam int SQW = 2 * F + 3;
	localparam int DW  = 2 * F + 4;
	localparam int SW  = F + 2;

	logic [F:0] feat_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_tab
		assign feat_tab[g] = (F + 1)'(((g << F) + 127) / 255);
	end

	logic signed [IW-1:0] xi_s2, yi_s2;
	logic [F-1:0]         xf_s2, yf_s2, xf_s3, yf_s3, xf_s4, yf_s4, xf_s5, yf_s5;
	logic [31:0]          hx_s3, hy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			xi_s2 <= px[PW-1:F];
			yi_s2 <= py[PW-1:F];
			xf_s2 <= px[F-1:0];
			yf_s2 <= py[F-1:0];
			hx_s3 <= 32'(xi_s2) * HASH_MUL_X;
			hy_s3 <= 32'(yi_s2) * HASH_MUL_Y;
			xf_s3 <= xf_s2;
			yf_s3 <= yf_s2;
			xf_s4 <= xf_s3;
			yf_s4 <= yf_s3;
			xf_s5 <= xf_s4;
			yf_s5 <= yf_s4;
		end
	end

	logic [31:0]           mix_s4 [9];
	logic [31:0]           prod_s5 [9];
	logic signed [DXW-1:0] dx_s6 [9];
	logic signed [DXW-1:0] dy_s6 [9];
	logic [SQW-1:0]        sqx_s7 [9];
	logic [SQW-1:0]        sqy_s7 [9];
	logic [DW-1:0]         d_s8 [9];

	for (genvar k = 0; k < 9; k++) begin : g_cell
		localparam int GI = k % 3;
		localparam int GJ = k / 3;
		localparam logic [31:0] OFFX = (GI == 0) ? (32'd0 - HASH_MUL_X) :
			(GI == 2) ? HASH_MUL_X : 32'd0;
		localparam logic [31:0] OFFY = (GJ == 0) ? (32'd0 - HASH_MUL_Y) :
			(GJ == 2) ? HASH_MUL_Y : 32'd0;
		localparam logic signed [DXW-1:0] CX = DXW'((GI - 1) * (1 << F));
		localparam logic signed [DXW-1:0] CY = DXW'((GJ - 1) * (1 << F));

		logic [31:0]             h0, hf;
		logic [F:0]              fx, fy;
		logic signed [2*DXW-1:0] sqx_w, sqy_w;

		assign h0    = hx_s3 + hy_s3 + OFFX + OFFY;
		assign hf    = prod_s5[k] ^ (prod_s5[k] >> 16);
		assign fx    = feat_tab[hf[7:0]];
		assign fy    = feat_tab[hf[15:8]];
		assign sqx_w = dx_s6[k] * dx_s6[k];
		assign sqy_w = dy_s6[k] * dy_s6[k];

		always_ff @(posedge clk) begin
			if (en) begin
				mix_s4[k]  <= h0 ^ (h0 >> 13);
				prod_s5[k] <= mix_s4[k] * HASH_MIX;
				dx_s6[k]   <= CX + $signed(DXW'(fx)) - $signed(DXW'(xf_s5));
				dy_s6[k]   <= CY + $signed(DXW'(fy)) - $signed(DXW'(yf_s5));
				sqx_s7[k]  <= sqx_w[SQW-1:0];
				sqy_s7[k]  <= sqy_w[SQW-1:0];
				d_s8[k]    <= DW'(sqx_s7[k]) + DW'(sqy_s7[k]);
			end
		end
	end

	logic [DW-1:0] min3_s9 [3];
	logic [DW-1:0] m01 [3];
	logic [DW-1:0] m3_w [3];
	logic [DW-1:0] ma, mb;

	for (genvar g = 0; g < 3; g++) begin : g_min
		assign m01[g]  = (d_s8[3*g+1] < d_s8[3*g]) ? d_s8[3*g+1] : d_s8[3*g];
		assign m3_w[g] = (d_s8[3*g+2] < m01[g]) ? d_s8[3*g+2] : m01[g];
	end

	assign ma = (min3_s9[1] < min3_s9[0]) ? min3_s9[1] : min3_s9[0];
	assign mb = (min3_s9[2] < ma) ? min3_s9[2] : ma;

	// Root pipeline: stage 0 holds the minimum, each stage settles one root bit.
	logic [DW-1:0]   rad_q  [SW+1];
	logic [SW+1:0]   rem_q  [SW+1];
	logic [SW-1:0]   root_q [SW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < 3; g++) begin
				min3_s9[g] <= m3_w[g];
			end
			rad_q[0]  <= mb;
			rem_q[0]  <= '0;
			root_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_root
		logic [SW+1:0] cur, trial;
		assign cur   = {rem_q[k][SW-1:0], rad_q[k][DW-1:DW-2]};
		assign trial = {root_q[k], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k+1] <= {rad_q[k][DW-3:0], 2'b00};
				if (cur >= trial) begin
					rem_q[k+1]  <= cur - trial;
					root_q[k+1] <= {root_q[k][SW-2:0], 1'b1};
				end else begin
					rem_q[k+1]  <= cur;
					root_q[k+1] <= {root_q[k][SW-2:0], 1'b0};
				end
			end
		end
	end

	assign nval = root_q[SW];

endmodule

/* hdl/worley_noise_pixel_warp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worley_noise_pixel_warp
// Cellular-noise displacement warp over a stored source frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per cycle while
//   in_stall is low. A load item (operation 0) writes pixel_in into the frame
//   store at (col, row) when the position lies inside the active frame; it
//   gives no result. A compute item (operation 1) gives one result on the
//   output channel (out_valid / out_stall): the source pixel at the
//   noise-displaced position and in_frame. Throughput is one item per cycle
//   while in_stall is low; loads and computes may be mixed freely. A compute
//   item's delay comes from the two parallel noise pipelines, mostly their
//   one-bit-per-stage root. Loads write the store at the same stage where
//   computes read it, so item order is kept without any interlock.
//   An output register plus a one-entry skid part the channels; in_stall rises
//   only once the skid holds a result, and the whole pipeline then holds.
//   Reset clears the registers to their defaults and empties the pipeline; the
//   frame store is not cleared and must be loaded before it is read.
//   Configuration must be written through cfg_write / cfg_index / cfg_data
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module worley_noise_pixel_warp #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC_BITS  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [8:0]  col,
	input  logic [8:0]  row,
	input  logic [7:0]  pixel_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  sample,
	output logic        in_frame
);
	import wly_pkg::*;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_FREQUENCY    = 3'd2;
	localparam logic [2:0] REG_STRENGTH     = 3'd3;
	localparam logic [2:0] REG_SHIFT_X1     = 3'd4;
	localparam logic [2:0] REG_SHIFT_Y1     = 3'd5;
	localparam logic [2:0] REG_SHIFT_X2     = 3'd6;
	localparam logic [2:0] REG_SHIFT_Y2     = 3'd7;

	localparam int F      = FRAC_BITS;
	localparam int PW     = 27;
	localparam int SW     = F + 2;
	localparam int PRW    = SW + 17;
	localparam int SH     = F + 8;
	localparam int SSW    = F + 20;
	localparam int QW     = SSW - SH;
	localparam int LAT    = noise_lat(F);
	localparam int PL     = LAT + 3;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int EWW    = $clog2(MAX_WIDTH + 1);
	localparam int EWH    = $clog2(MAX_HEIGHT + 1);
	localparam int EW0    = (EWW > EWH) ? EWW : EWH;
	localparam int EW     = (EW0 > QW) ? EW0 : QW;

	// Configuration registers
	logic [9:0]         frame_width_q, frame_height_q;
	logic [15:0]        noise_frequency_q;
	logic signed [15:0] displace_strength_q;
	logic signed [11:0] shift_x1_q, shift_y1_q, shift_x2_q, shift_y2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q       <= 10'd512;
			frame_height_q      <= 10'd512;
			noise_frequency_q   <= 16'd4096;
			displace_strength_q <= 16'sd768;
			shift_x1_q          <= '0;
			shift_y1_q          <= '0;
			shift_x2_q          <= '0;
			shift_y2_q          <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q       <= cfg_data[9:0];
				REG_FRAME_HEIGHT: frame_height_q      <= cfg_data[9:0];
				REG_FREQUENCY:    noise_frequency_q   <= cfg_data;
				REG_STRENGTH:     displace_strength_q <= $signed(cfg_data);
				REG_SHIFT_X1:     shift_x1_q          <= $signed(cfg_data[11:0]);
				REG_SHIFT_Y1:     shift_y1_q          <= $signed(cfg_data[11:0]);
				REG_SHIFT_X2:     shift_x2_q          <= $signed(cfg_data[11:0]);
				REG_SHIFT_Y2:     shift_y2_q          <= $signed(cfg_data[11:0]);
				default: ;
			endcase
		end
	end

	logic [EW-1:0] w_eff, h_eff;
	assign w_eff = (EW'(frame_width_q) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(frame_width_q);
	assign h_eff = (EW'(frame_height_q) > EW'(MAX_HEIGHT)) ?
		EW'(MAX_HEIGHT) : EW'(frame_height_q);

	// Flow control
	logic skid_full_q, out_valid_q, adv, accept;
	assign adv      = !skid_full_q;
	assign in_stall = skid_full_q;
	assign accept   = in_valid && !in_stall;

	// Item control through the pipeline
	logic       vld_q [PL];
	logic       op_q  [PL];
	logic [8:0] col_q [PL];
	logic [8:0] row_q [PL];
	logic [7:0] pix_q [PL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PL; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= accept;
			for (int k = 1; k < PL; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_q[0]  <= operation;
			col_q[0] <= col;
			row_q[0] <= row;
			pix_q[0] <= pixel_in;
			for (int k = 1; k < PL; k++) begin
				op_q[k]  <= op_q[k-1];
				col_q[k] <= col_q[k-1];
				row_q[k] <= row_q[k-1];
				pix_q[k] <= pix_q[k-1];
			end
		end
	end

	// Stage 1: scaled coordinates
	logic [24:0] sc_s1, sr_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s1 <= col * noise_frequency_q;
			sr_s1 <= row * noise_frequency_q;
		end
	end

	logic signed [PW-1:0] px1, py1, px2, py2;
	assign px1 = $signed(PW'(sc_s1)) + PW'(shift_x1_q);
	assign py1 = $signed(PW'(sr_s1)) + PW'(shift_y1_q);
	assign px2 = $signed(PW'(sr_s1)) + PW'(shift_x2_q);
	assign py2 = $signed(PW'(sc_s1)) + PW'(shift_y2_q);

	logic [SW-1:0] n1, n2;

	wly_noise #(.FRAC_BITS(F), .PW(PW)) u_noise_first (
		.clk (clk), .en (adv), .px (px1), .py (py1), .nval (n1)
	);

	wly_noise #(.FRAC_BITS(F), .PW(PW)) u_noise_second (
		.clk (clk), .en (adv), .px (px2), .py (py2), .nval (n2)
	);

	// Gain and truncation toward zero
	logic signed [PRW-1:0] prodx_w, prody_w, prodx_sa, prody_sa;
	logic signed [SSW-1:0] sx, sy;
	logic [SSW-1:0]        magx, magy;
	logic [QW-1:0]         qx, qy;
	logic signed [QW:0]    ix_sb, iy_sb;

	assign prodx_w = $signed({1'b0, n1}) * displace_strength_q;
	assign prody_w = $signed({1'b0, n2}) * displace_strength_q;
	assign sx   = $signed({{(SSW-9-SH){1'b0}}, col_q[LAT+1], {SH{1'b0}}}) + SSW'(prodx_sa);
	assign sy   = $signed({{(SSW-9-SH){1'b0}}, row_q[LAT+1], {SH{1'b0}}}) + SSW'(prody_sa);
	assign magx = sx[SSW-1] ? SSW'(-sx) : SSW'(sx);
	assign magy = sy[SSW-1] ? SSW'(-sy) : SSW'(sy);
	assign qx   = magx[SSW-1:SH];
	assign qy   = magy[SSW-1:SH];

	always_ff @(posedge clk) begin
		if (adv) begin
			prodx_sa <= prodx_w;
			prody_sa <= prody_w;
			ix_sb    <= sx[SSW-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
			iy_sb    <= sy[SSW-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		end
	end

	// Frame store access: loads write and computes read at the same stage
	logic          src_ok, ld_ok, ram_we;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [7:0]    rdata;

	assign src_ok  = !ix_sb[QW] && !iy_sb[QW] &&
		(EW'(ix_sb[QW-1:0]) < w_eff) && (EW'(iy_sb[QW-1:0]) < h_eff);
	assign ld_ok   = (EW'(col_q[PL-1]) < w_eff) && (EW'(row_q[PL-1]) < h_eff);
	assign ram_we  = adv && vld_q[PL-1] && !op_q[PL-1] && ld_ok;
	assign rd_addr = AW'(EW'(iy_sb[QW-1:0]) * MAX_WIDTH + EW'(ix_sb[QW-1:0]));
	assign wr_addr = AW'(row_q[PL-1] * MAX_WIDTH + col_q[PL-1]);

	wly_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (pix_q[PL-1]),
		.re    (adv),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	logic vd_q, opd_q, ind_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_q <= 1'b0;
		end else if (adv) begin
			vd_q <= vld_q[PL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			opd_q <= op_q[PL-1];
			ind_q <= src_ok;
		end
	end

	// Output register and skid
	logic       push, take, load_out;
	logic [7:0] new_sample, sample_q, skid_sample_q;
	logic       in_frame_q, skid_frame_q;

	assign push       = adv && vd_q && opd_q;
	assign take       = out_valid_q && !out_stall;
	assign load_out   = !out_valid_q || take;
	assign new_sample = ind_q ? rdata : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (load_out) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_full_q) begin
				sample_q   <= skid_sample_q;
				in_frame_q <= skid_frame_q;
			end else if (push) begin
				sample_q   <= new_sample;
				in_frame_q <= ind_q;
			end
		end else if (push) begin
			skid_sample_q <= new_sample;
			skid_frame_q  <= ind_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign in_frame  = in_frame_q;

endmodule

/* hdl/wly_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wly_checker
// Port-level checks of the pixel warp, bound to the top level.
// ----------------------------------------------------------------------------
module wly_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] sample,
	input logic       in_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sample) && $stable(in_frame))
		else $error("stalled result changed");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_frame |-> sample == 8'd0)
		else $error("sample not zero outside frame");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

bind worley_noise_pixel_warp wly_checker u_chk (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cellular-noise pixel warp testbench
// Loads source pixels, sends compute items and checks each warped pixel
// against a behavioral prediction of the noise, displacement and frame store.
// Runs directed corners, register extremes and random traffic with idling.
// ----------------------------------------------------------------------------
module testbench;
	import wly_pkg::*;

	localparam int FRAC      = 12;
	localparam int MAXW      = 512;
	localparam int MAXH      = 512;
	localparam int DRAIN     = 40;
	localparam int CYCLE_CAP = 600000;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [2:0] REG_WIDTH    = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_FREQ     = 3'd2;
	localparam logic [2:0] REG_STRENGTH = 3'd3;
	localparam logic [2:0] REG_SHX1     = 3'd4;
	localparam logic [2:0] REG_SHY1     = 3'd5;
	localparam logic [2:0] REG_SHX2     = 3'd6;
	localparam logic [2:0] REG_SHY2     = 3'd7;

	typedef struct {
		logic [7:0] sample;
		logic       in_frame;
	} warp_pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_LOAD;
	logic [8:0]  col = '0;
	logic [8:0]  row = '0;
	logic [7:0]  pixel_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  sample;
	logic        in_frame;

	worley_noise_pixel_warp uut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [7:0]  frame_mem [MAXW*MAXH];
	bit          frame_loaded [MAXW*MAXH];
	int          fw = 512, fh = 512, freq = 4096, gain = 768;
	int          shx1 = 0, shy1 = 0, shx2 = 0, shy2 = 0;
	warp_pixel_t pending_pixels [$];

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	int  errors = 0;
	int  cycles = 0;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint cell_noise(longint px, longint py);
		longint xi = px >>> FRAC;
		longint yi = py >>> FRAC;
		longint cx, cy, fx, fy, dx, dy;
		longint unsigned d, best;
		bit [31:0] h;
		best = '1;
		for (int j = -1; j <= 1; j++) begin
			for (int i = -1; i <= 1; i++) begin
				cx = xi + i;
				cy = yi + j;
				h = cx[31:0] * HASH_MUL_X + cy[31:0] * HASH_MUL_Y;
				h = (h ^ (h >> 13)) * HASH_MIX;
				h = h ^ (h >> 16);
				fx = ((longint'(h[7:0]) << FRAC) + 127) / 255;
				fy = ((longint'(h[15:8]) << FRAC) + 127) / 255;
				dx = (cx <<< FRAC) + fx - px;
				dy = (cy <<< FRAC) + fy - py;
				d = dx * dx + dy * dy;
				if (d < best)
					best = d;
			end
		end
		return longint'(root_floor(best));
	endfunction

	// truncate toward zero after adding the scaled noise
	function automatic longint displace(int base, longint n);
		longint s = (longint'(base) <<< (FRAC + 8)) + n * gain;
		if (s >= 0)
			return s >>> (FRAC + 8);
		return -((-s) >>> (FRAC + 8));
	endfunction

	function automatic int eff_w();
		return (fw < MAXW) ? fw : MAXW;
	endfunction

	function automatic int eff_h();
		return (fh < MAXH) ? fh : MAXH;
	endfunction

	task automatic send_item(logic op, int c, int r, int pix);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		col       <= c[8:0];
		row       <= r[8:0];
		pixel_in  <= pix[7:0];
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_pixel(int c, int r, int pix);
		if (c < eff_w() && r < eff_h()) begin
			frame_mem[r*MAXW + c] = pix[7:0];
			frame_loaded[r*MAXW + c] = 1'b1;
		end
		send_item(OP_LOAD, c, r, pix);
	endtask

	// load the source pixel first when the warp would land on an unwritten one
	task automatic compute_pixel(int c, int r);
		longint sc = longint'(c) * freq;
		longint sr = longint'(r) * freq;
		longint ix = displace(c, cell_noise(sc + shx1, sr + shy1));
		longint iy = displace(r, cell_noise(sr + shx2, sc + shy2));
		warp_pixel_t exp_px;
		exp_px.sample = '0;
		exp_px.in_frame = 1'b0;
		if (ix >= 0 && iy >= 0 && ix < eff_w() && iy < eff_h()) begin
			if (!frame_loaded[iy*MAXW + ix])
				load_pixel(int'(ix), int'(iy), $urandom_range(255));
			exp_px.sample = frame_mem[iy*MAXW + ix];
			exp_px.in_frame = 1'b1;
		end
		pending_pixels.push_back(exp_px);
		send_item(OP_COMPUTE, c, r, $urandom_range(255));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		drop_valid();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		wait_drained();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[15:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WIDTH:    fw = value & 'h3FF;
			REG_HEIGHT:   fh = value & 'h3FF;
			REG_FREQ:     freq = value & 'hFFFF;
			REG_STRENGTH: gain = int'($signed(value[15:0]));
			REG_SHX1:     shx1 = int'($signed(value[11:0]));
			REG_SHY1:     shy1 = int'($signed(value[11:0]));
			REG_SHX2:     shx2 = int'($signed(value[11:0]));
			REG_SHY2:     shy2 = int'($signed(value[11:0]));
			default: ;
		endcase
	endtask

	task automatic set_shifts(int a, int b, int c, int d);
		write_reg(REG_SHX1, a);
		write_reg(REG_SHY1, b);
		write_reg(REG_SHX2, c);
		write_reg(REG_SHY2, d);
	endtask

	task automatic test_corners();
		load_pixel(0, 0, 8'h00);
		load_pixel(511, 511, 8'hFF);
		load_pixel(511, 0, 8'hA5);
		load_pixel(0, 511, 8'h5A);
		compute_pixel(0, 0);
		compute_pixel(511, 511);
		compute_pixel(511, 0);
		compute_pixel(0, 511);
		compute_pixel(255, 256);
	endtask

	task automatic test_frame_limits();
		write_reg(REG_WIDTH, 16);
		write_reg(REG_HEIGHT, 16);
		// ignored: outside the active frame
		load_pixel(20, 3, 8'h77);
		load_pixel(3, 300, 8'h66);
		// own position outside the frame is still warped
		compute_pixel(300, 5);
		compute_pixel(8, 8);
		write_reg(REG_WIDTH, 0);
		load_pixel(0, 0, 8'h11);
		compute_pixel(0, 0);
		compute_pixel(4, 4);
		write_reg(REG_WIDTH, 1023);
		write_reg(REG_HEIGHT, 1023);
		compute_pixel(511, 511);
		write_reg(REG_WIDTH, 1);
		write_reg(REG_HEIGHT, 1);
		compute_pixel(0, 0);
		compute_pixel(1, 0);
	endtask

	task automatic test_gain_and_phase();
		write_reg(REG_WIDTH, 512);
		write_reg(REG_HEIGHT, 512);
		write_reg(REG_FREQ, 0);
		write_reg(REG_STRENGTH, 32767);
		set_shifts(2047, -2048, -2048, 2047);
		compute_pixel(100, 200);
		compute_pixel(0, 0);
		write_reg(REG_FREQ, 65535);
		write_reg(REG_STRENGTH, -32768);
		compute_pixel(511, 511);
		compute_pixel(37, 480);
		set_shifts(-2048, 2047, 2047, -2048);
		write_reg(REG_STRENGTH, 0);
		compute_pixel(123, 45);
	endtask

	task automatic test_random_traffic();
		int lim_w, lim_h;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			write_reg(REG_WIDTH, (ph % 3 == 0) ? $urandom_range(1023) : $urandom_range(64, 8));
			write_reg(REG_HEIGHT, (ph % 3 == 0) ? $urandom_range(1023) : $urandom_range(64, 8));
			write_reg(REG_FREQ, (ph % 2) ? $urandom_range(65535) : $urandom_range(8192, 256));
			write_reg(REG_STRENGTH, (ph % 2) ? $urandom_range(65535) : $urandom_range(4096));
			set_shifts($urandom_range(4095), $urandom_range(4095),
				$urandom_range(4095), $urandom_range(4095));
			lim_w = (eff_w() > 0) ? eff_w() : 1;
			lim_h = (eff_h() > 0) ? eff_h() : 1;
			for (int k = 0; k < 85; k++) begin
				case ($urandom_range(9))
					0, 1, 2, 3: load_pixel($urandom_range(lim_w - 1), $urandom_range(lim_h - 1),
						$urandom_range(255));
					4: load_pixel($urandom_range(511), $urandom_range(511), $urandom_range(255));
					5: compute_pixel($urandom_range(511), $urandom_range(511));
					default: compute_pixel($urandom_range(lim_w - 1), $urandom_range(lim_h - 1));
				endcase
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		warp_pixel_t got;
		if (out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("result with nothing expected: sample %0d in_frame %0d", sample, in_frame);
				errors++;
			end else begin
				got = pending_pixels.pop_front();
				if (sample !== got.sample) begin
					$error("sample: expected %0d, got %0d", got.sample, sample);
					errors++;
				end
				if (in_frame !== got.in_frame) begin
					$error("in_frame: expected %0d, got %0d", got.in_frame, in_frame);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_corners();
		test_frame_limits();
		test_gain_and_phase();
		test_random_traffic();
		wait_drained();
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
